// ----- rtl/core/upc_pkg.sv -----
`default_nettype none

package upc_pkg;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // command queue between front and back; depth is a power of two
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_out;
    logic       bad_escape;
  } out_item_t;

  // one classified item: a single word, or a three-word escape of byte_val
  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
    logic       err;
    logic       triple;
  } cmd_t;

  function automatic logic is_reserved(input logic [7:0] b);
    logic hit;
    begin
      case (b)
        8'h25, 8'h21, 8'h23, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
        8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D: hit = 1'b1;
        default: hit = 1'b0;
      endcase
      return hit;
    end
  endfunction

  // upper-case hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    begin
      if (n < 4'd10) begin
        c = {4'h3, n};
      end else begin
        c = 8'h37 + {4'h0, n};
      end
      return c;
    end
  endfunction

  // {valid, nibble} of an upper-case hex character
  function automatic logic [4:0] hex_val(input logic [7:0] d);
    logic [4:0] r;
    begin
      if (d >= 8'h30 && d <= 8'h39) begin
        r = {1'b1, d[3:0]};
      end else if (d >= 8'h41 && d <= 8'h46) begin
        r = {1'b1, d[3:0] + 4'd9};
      end else begin
        r = 5'd0;
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/upc_front.sv -----
`default_nettype none

module upc_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 mode_we,
  input  wire                 mode_wdata,
  input  wire                 accept,
  input  upc_pkg::in_item_t   item,
  output logic                cmd_wr,
  output upc_pkg::cmd_t       cmd
);
  import upc_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  logic       mode;
  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] first_digit;
  logic [7:0] first_digit_next;
  logic       have;
  logic [4:0] hv1;
  logic [4:0] hv2;
  logic [7:0] decoded;
  logic       known;

  always_comb begin
    hv1     = hex_val(first_digit);
    hv2     = hex_val(item.byte_in);
    decoded = {hv1[3:0], hv2[3:0]};
    known   = hv1[4] && hv2[4] && is_reserved(decoded);
  end

  always_comb begin
    phase_next       = phase;
    first_digit_next = first_digit;
    have             = 1'b0;
    cmd.byte_val     = item.byte_in;
    cmd.last         = item.end_of_string;
    cmd.err          = 1'b0;
    cmd.triple       = 1'b0;
    if (!mode) begin
      phase_next       = PH_IDLE;
      first_digit_next = 8'd0;
      have             = 1'b1;
      if (is_reserved(item.byte_in)) begin
        cmd.triple = 1'b1;
      end else if (item.byte_in == CHAR_SPACE) begin
        cmd.byte_val = CHAR_PLUS;
      end
    end else begin
      unique case (phase)
        PH_FIRST: begin
          first_digit_next = item.byte_in;
          phase_next       = PH_SECOND;
        end
        PH_SECOND: begin
          have             = 1'b1;
          cmd.byte_val     = known ? decoded : 8'd0;
          cmd.err          = !known;
          phase_next       = PH_IDLE;
          first_digit_next = 8'd0;
        end
        default: begin
          if (item.byte_in == CHAR_PCT) begin
            phase_next = PH_FIRST;
          end else if (item.byte_in == CHAR_PLUS) begin
            have         = 1'b1;
            cmd.byte_val = CHAR_SPACE;
          end else begin
            have = 1'b1;
          end
        end
      endcase
      // escape cut off by the end of the string
      if (item.end_of_string && phase_next != PH_IDLE) begin
        have         = 1'b1;
        cmd.byte_val = 8'd0;
        cmd.err      = 1'b1;
      end
    end
    if (item.end_of_string) begin
      phase_next       = PH_IDLE;
      first_digit_next = 8'd0;
    end
  end

  assign cmd_wr = accept && have;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b0;
      phase       <= PH_IDLE;
      first_digit <= 8'd0;
    end else if (mode_we) begin
      mode        <= mode_wdata;
      phase       <= PH_IDLE;
      first_digit <= 8'd0;
    end else if (accept) begin
      phase       <= phase_next;
      first_digit <= first_digit_next;
    end
  end

  a_encode_no_escape: assert property (@(posedge clk) disable iff (rst)
    (accept && !mode && !mode_we) |=> (phase == PH_IDLE))
    else $error("escape state left set in encode mode");

endmodule

`default_nettype wire

// ----- rtl/core/upc_queue.sv -----
`default_nettype none

module upc_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            wr,
  input  upc_pkg::cmd_t  wr_cmd,
  output logic           full,
  input  wire            rd,
  output logic           head_valid,
  output upc_pkg::cmd_t  head
);
  import upc_pkg::*;

  cmd_t                 mem [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_wr;
  logic                 do_rd;

  assign full       = (count == CMD_CNT_W'(CMD_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_wr      = wr && !full;
  assign do_rd      = rd && head_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> !full)
    else $error("command written into a full queue");

endmodule

`default_nettype wire

// ----- rtl/core/upc_back.sv -----
`default_nettype none

module upc_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 head_valid,
  input  upc_pkg::cmd_t       head,
  output logic                head_rd,
  output logic                empty,
  input  wire                 pop,
  output upc_pkg::out_item_t  result
);
  import upc_pkg::*;

  localparam logic [1:0] WORD_PCT = 2'd0;
  localparam logic [1:0] WORD_HI  = 2'd1;
  localparam logic [1:0] WORD_LO  = 2'd2;

  logic       out_valid;
  out_item_t  out_word;
  out_item_t  word_next;
  logic [1:0] idx;
  logic       load;
  logic       final_word;

  always_comb begin
    unique case (idx)
      WORD_PCT: word_next.byte_out = head.triple ? CHAR_PCT : head.byte_val;
      WORD_HI:  word_next.byte_out = hex_char(head.byte_val[7:4]);
      default:  word_next.byte_out = hex_char(head.byte_val[3:0]);
    endcase
    final_word            = !head.triple || (idx == WORD_LO);
    word_next.last_out    = head.last && final_word;
    word_next.bad_escape  = head.err;
  end

  // advance when the output register is free or being drained
  assign load    = head_valid && (!out_valid || pop);
  assign head_rd = load && final_word;
  assign empty   = !out_valid;
  assign result  = out_word;

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= WORD_PCT;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        idx <= final_word ? WORD_PCT : idx + 1'b1;
      end
    end
  end

  a_mid_escape: assert property (@(posedge clk) disable iff (rst)
    (idx != WORD_PCT) |-> (head_valid && head.triple))
    else $error("escape word index advanced without a three-word command");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.bad_escape) |-> (out_word.byte_out == 8'd0))
    else $error("bad escape word carries a non-zero byte");

endmodule

`default_nettype wire

// ----- rtl/core/url_percent_codec.sv -----
`default_nettype none
// Channel   Direction  Handshake           Payload
// item      in         push / full         in_item_t  {byte_in, end_of_string}
// result    out        pop / empty         out_item_t {byte_out, last_out, bad_escape}
// mode      in         mode_we             mode_wdata (0 encode, 1 decode)
//
// Each input word is classified in the cycle it is accepted; one that completes
// a character is queued as a command. The back end emits one result word per cycle
// while results are popped: one per command, three for an encoded reserved byte.
// A two-entry command queue and the output register let either side stall alone.
// Synchronous reset sets encode mode and clears the escape state, queue and output.

module url_percent_codec (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  output logic                full,
  input  upc_pkg::in_item_t   item,
  output logic                empty,
  input  wire                 pop,
  output upc_pkg::out_item_t  result,
  input  wire                 mode_we,
  input  wire                 mode_wdata
);
  import upc_pkg::*;

  logic cmd_wr;
  cmd_t cmd;
  logic head_valid;
  cmd_t head;
  logic head_rd;

  upc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .accept     (push && !full),
    .item       (item),
    .cmd_wr     (cmd_wr),
    .cmd        (cmd)
  );

  upc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr         (cmd_wr),
    .wr_cmd     (cmd),
    .full       (full),
    .rd         (head_rd),
    .head_valid (head_valid),
    .head       (head)
  );

  upc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_rd    (head_rd),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

`default_nettype wire
